// ----- rtl/core/rcoms_pkg.sv -----
`default_nettype none

package rcoms_pkg;

   // Field widths
   localparam int PULSE_W  = 16;
   localparam int CODE_W   = 8;
   localparam int COUNT_W  = 8;
   localparam int WINDOW_W = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Centering window length and tolerance around the centre pulse width
   localparam int CENTER_WINDOW_ITEMS = 10;
   localparam int CENTER_TOLERANCE    = 50;

   // Register reset values
   localparam logic [PULSE_W-1:0] RST_THROTTLE_ON    = 16'd1200;
   localparam logic [PULSE_W-1:0] RST_THROTTLE_BRAKE = 16'd1300;
   localparam logic [PULSE_W-1:0] RST_STEER_ACT      = 16'd1800;
   localparam logic [PULSE_W-1:0] RST_STEER_DEACT    = 16'd1200;
   localparam logic [PULSE_W-1:0] RST_CENTERED_PULSE = 16'd1500;
   localparam logic [COUNT_W-1:0] RST_ITERATIONS     = 8'd20;
   localparam logic [CODE_W-1:0]  RST_SPEED_STOP     = 8'd0;
   localparam logic [CODE_W-1:0]  RST_CENTERED_ANGLE = 8'd90;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THROTTLE_ON    = 3'd0,
      CSR_THROTTLE_BRAKE = 3'd1,
      CSR_STEER_ACT      = 3'd2,
      CSR_STEER_DEACT    = 3'd3,
      CSR_CENTERED_PULSE = 3'd4,
      CSR_ITERATIONS     = 3'd5,
      CSR_SPEED_STOP     = 3'd6,
      CSR_CENTERED_ANGLE = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [PULSE_W-1:0] throttle_on_threshold;
      logic [PULSE_W-1:0] throttle_brake_threshold;
      logic [PULSE_W-1:0] steering_activation_threshold;
      logic [PULSE_W-1:0] steering_deactivation_threshold;
      logic [PULSE_W-1:0] centered_pulse_width;
      logic [COUNT_W-1:0] iterations_to_change;
      logic [CODE_W-1:0]  speed_stop_value;
      logic [CODE_W-1:0]  centered_angle_value;
   } cfg_type;

   typedef struct packed {
      logic               mode;
      logic [PULSE_W-1:0] throttle_width;
      logic [PULSE_W-1:0] steering_width;
      logic [CODE_W-1:0]  drive_speed;
      logic [CODE_W-1:0]  drive_angle;
   } req_item_type;

   typedef struct packed {
      logic               esc_write;
      logic [CODE_W-1:0]  esc_value;
      logic               servo_write;
      logic [CODE_W-1:0]  servo_value;
      logic               rc_forward;
      logic [PULSE_W-1:0] rc_throttle_out;
      logic [PULSE_W-1:0] rc_steering_out;
      logic               led_on;
      logic               rc_mode_active;
   } rsp_item_type;

endpackage

`default_nettype wire

// ----- rtl/core/rcoms_req_if.sv -----
`default_nettype none

interface rcoms_req_if;
   logic                           valid;
   logic                           ready;
   logic                           mode;
   logic [rcoms_pkg::PULSE_W-1:0]  throttle_width;
   logic [rcoms_pkg::PULSE_W-1:0]  steering_width;
   logic [rcoms_pkg::CODE_W-1:0]   drive_speed;
   logic [rcoms_pkg::CODE_W-1:0]   drive_angle;

   modport source (
      output valid, mode, throttle_width, steering_width, drive_speed, drive_angle,
      input  ready
   );

   modport sink (
      input  valid, mode, throttle_width, steering_width, drive_speed, drive_angle,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/rcoms_rsp_if.sv -----
`default_nettype none

interface rcoms_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           esc_write;
   logic [rcoms_pkg::CODE_W-1:0]   esc_value;
   logic                           servo_write;
   logic [rcoms_pkg::CODE_W-1:0]   servo_value;
   logic                           rc_forward;
   logic [rcoms_pkg::PULSE_W-1:0]  rc_throttle_out;
   logic [rcoms_pkg::PULSE_W-1:0]  rc_steering_out;
   logic                           led_on;
   logic                           rc_mode_active;

   modport source (
      output valid, esc_write, esc_value, servo_write, servo_value, rc_forward,
             rc_throttle_out, rc_steering_out, led_on, rc_mode_active,
      input  ready
   );

   modport sink (
      input  valid, esc_write, esc_value, servo_write, servo_value, rc_forward,
             rc_throttle_out, rc_steering_out, led_on, rc_mode_active,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/rc_override_mode_switch.sv -----
// RC override mode switch.
// One request transfer on req_ch is one control iteration: RC throttle and
// steering pulse widths plus a drive command or a stop-and-centre request.
// Each request gives exactly one response on rsp_ch with the ESC and servo
// writes, the forwarded RC pulses in RC mode, the LED level and the mode flag.
// Registers are written through csr_write_enable / csr_index /
// csr_write_data, one register per cycle; the user must write them only while
// no item is in flight, as the block itself does not enforce this. An input
// register and a result register bracket a single pass of compare and select
// logic. Throughput: one item per cycle while rsp_ch.ready stays high; the
// mode-check state updates as the item leaves the input register, when its
// throttle is above the on threshold.
// Reset (synchronous, active high) empties both registers, returns the block
// to autonomous mode with all counters, windows and the LED cleared, and loads
// the register defaults. When the receiver holds rsp_ch.ready low, the
// result stays put, one further request may still be taken into the input
// register, and then req_ch.ready drops until the response is taken.
`default_nettype none

module rc_override_mode_switch (
   input  wire logic                                clock,
   input  wire logic                                reset,
   rcoms_req_if.sink                                req_ch,
   rcoms_rsp_if.source                              rsp_ch,
   input  wire logic                                csr_write_enable,
   input  wire logic [rcoms_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rcoms_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   rcoms_pkg::cfg_type        cfg;
   rcoms_pkg::req_item_type   req_item;
   rcoms_pkg::req_item_type   in_item_ff;
   rcoms_pkg::rsp_item_type   result;
   rcoms_pkg::rsp_item_type   out_item_ff;
   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic                      advance;
   logic                      fire;
   logic                      req_take;

   rcoms_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   assign req_item.mode           = req_ch.mode;
   assign req_item.throttle_width = req_ch.throttle_width;
   assign req_item.steering_width = req_ch.steering_width;
   assign req_item.drive_speed    = req_ch.drive_speed;
   assign req_item.drive_angle    = req_ch.drive_angle;

   // Move the item on when the result register is free or being emptied
   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = fire || (out_valid_ff && !rsp_ch.ready);

   rcoms_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (in_item_ff),
      .result (result)
   );

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Load payloads on transfer
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (fire) begin
         out_item_ff <= result;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.esc_write       = out_item_ff.esc_write;
   assign rsp_ch.esc_value       = out_item_ff.esc_value;
   assign rsp_ch.servo_write     = out_item_ff.servo_write;
   assign rsp_ch.servo_value     = out_item_ff.servo_value;
   assign rsp_ch.rc_forward      = out_item_ff.rc_forward;
   assign rsp_ch.rc_throttle_out = out_item_ff.rc_throttle_out;
   assign rsp_ch.rc_steering_out = out_item_ff.rc_steering_out;
   assign rsp_ch.led_on          = out_item_ff.led_on;
   assign rsp_ch.rc_mode_active  = out_item_ff.rc_mode_active;

   // A waiting item stays in the input register while the output is stalled
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input item lost during a stall");

   // Forwarded results never also drive the ESC or servo
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.rc_forward) |->
         (!out_item_ff.esc_write && !out_item_ff.servo_write))
      else $error("forwarded result with a drive write");

endmodule

`default_nettype wire

// ----- rtl/core/rcoms_csr.sv -----
`default_nettype none

module rcoms_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [rcoms_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rcoms_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output rcoms_pkg::cfg_type                        cfg
);

   rcoms_pkg::cfg_type cfg_ff;
   rcoms_pkg::cfg_type cfg_in;

   // Decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (rcoms_pkg::csr_index_type'(csr_index))
            rcoms_pkg::CSR_THROTTLE_ON:
               cfg_in.throttle_on_threshold = csr_write_data;
            rcoms_pkg::CSR_THROTTLE_BRAKE:
               cfg_in.throttle_brake_threshold = csr_write_data;
            rcoms_pkg::CSR_STEER_ACT:
               cfg_in.steering_activation_threshold = csr_write_data;
            rcoms_pkg::CSR_STEER_DEACT:
               cfg_in.steering_deactivation_threshold = csr_write_data;
            rcoms_pkg::CSR_CENTERED_PULSE:
               cfg_in.centered_pulse_width = csr_write_data;
            rcoms_pkg::CSR_ITERATIONS:
               cfg_in.iterations_to_change = csr_write_data[rcoms_pkg::COUNT_W-1:0];
            rcoms_pkg::CSR_SPEED_STOP:
               cfg_in.speed_stop_value = csr_write_data[rcoms_pkg::CODE_W-1:0];
            rcoms_pkg::CSR_CENTERED_ANGLE:
               cfg_in.centered_angle_value = csr_write_data[rcoms_pkg::CODE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers, load reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.throttle_on_threshold           <= rcoms_pkg::RST_THROTTLE_ON;
         cfg_ff.throttle_brake_threshold        <= rcoms_pkg::RST_THROTTLE_BRAKE;
         cfg_ff.steering_activation_threshold   <= rcoms_pkg::RST_STEER_ACT;
         cfg_ff.steering_deactivation_threshold <= rcoms_pkg::RST_STEER_DEACT;
         cfg_ff.centered_pulse_width            <= rcoms_pkg::RST_CENTERED_PULSE;
         cfg_ff.iterations_to_change            <= rcoms_pkg::RST_ITERATIONS;
         cfg_ff.speed_stop_value                <= rcoms_pkg::RST_SPEED_STOP;
         cfg_ff.centered_angle_value            <= rcoms_pkg::RST_CENTERED_ANGLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/core/rcoms_core.sv -----
`default_nettype none

module rcoms_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rcoms_pkg::cfg_type      cfg,
   input  wire logic                    fire,
   input  wire rcoms_pkg::req_item_type item,
   output rcoms_pkg::rsp_item_type      result
);

   localparam int SUM_W = rcoms_pkg::PULSE_W + 1;
   localparam logic [rcoms_pkg::WINDOW_W-1:0] WINDOW_LOAD =
      rcoms_pkg::WINDOW_W'(rcoms_pkg::CENTER_WINDOW_ITEMS);
   localparam logic [SUM_W-1:0] TOL = SUM_W'(rcoms_pkg::CENTER_TOLERANCE);

   // Mode-check state
   logic                               rc_mode_ff;
   logic                               rc_mode_in;
   logic [rcoms_pkg::COUNT_W-1:0]      above_ff;
   logic [rcoms_pkg::COUNT_W-1:0]      above_in;
   logic [rcoms_pkg::COUNT_W-1:0]      below_ff;
   logic [rcoms_pkg::COUNT_W-1:0]      below_in;
   logic [rcoms_pkg::WINDOW_W-1:0]     act_win_ff;
   logic [rcoms_pkg::WINDOW_W-1:0]     act_win_in;
   logic [rcoms_pkg::WINDOW_W-1:0]     deact_win_ff;
   logic [rcoms_pkg::WINDOW_W-1:0]     deact_win_in;
   logic                               led_ff;
   logic                               led_in;

   logic                               check;
   logic                               centered;
   logic                               flag_mid;
   logic [rcoms_pkg::COUNT_W-1:0]      above_mid;
   logic [rcoms_pkg::COUNT_W-1:0]      below_mid;
   logic [rcoms_pkg::WINDOW_W-1:0]     act_mid;
   logic [rcoms_pkg::WINDOW_W-1:0]     deact_mid;
   logic                               steer_above_act;
   logic                               steer_below_deact;
   logic                               in_brake_band;
   logic                               forwarded;

   assign check = item.throttle_width > cfg.throttle_on_threshold;

   // Centred when steering lies strictly inside centre +/- tolerance, no wrap
   assign centered =
      (({1'b0, item.steering_width} + TOL) > {1'b0, cfg.centered_pulse_width}) &&
      ({1'b0, item.steering_width} < ({1'b0, cfg.centered_pulse_width} + TOL));

   assign steer_above_act   = item.steering_width > cfg.steering_activation_threshold;
   assign steer_below_deact = item.steering_width < cfg.steering_deactivation_threshold;

   // Work out the state after one mode check
   always_comb begin
      flag_mid = rc_mode_ff;
      if ((act_win_ff != '0) && centered) begin
         flag_mid = 1'b1;
      end else if ((deact_win_ff != '0) && centered) begin
         flag_mid = 1'b0;
      end

      above_mid = above_ff;
      below_mid = below_ff;
      act_mid   = act_win_ff;
      deact_mid = deact_win_ff;
      if (!flag_mid && steer_above_act) begin
         if (above_ff < cfg.iterations_to_change) begin
            above_mid = above_ff + 1'b1;
         end else begin
            act_mid = WINDOW_LOAD;
         end
      end else if (flag_mid && steer_below_deact) begin
         if (below_ff < cfg.iterations_to_change) begin
            below_mid = below_ff + 1'b1;
         end else begin
            deact_mid = WINDOW_LOAD;
         end
      end

      // Count down the open window, activation first
      act_win_in   = act_mid;
      deact_win_in = deact_mid;
      if (act_mid != '0) begin
         act_win_in = act_mid - 1'b1;
      end else if (deact_mid != '0) begin
         deact_win_in = deact_mid - 1'b1;
      end

      led_in = (act_win_in > deact_win_in) ? act_win_in[0] : deact_win_in[0];

      // Drop the below counter unless steering is below deactivation, else the above counter unless above activation
      above_in = above_mid;
      below_in = below_mid;
      if (!steer_below_deact) begin
         below_in = '0;
      end else if (!steer_above_act) begin
         above_in = '0;
      end

      rc_mode_in = flag_mid;
   end

   // Advance the state only on a transfer that runs a mode check
   always_ff @(posedge clock) begin
      if (reset) begin
         rc_mode_ff   <= 1'b0;
         above_ff     <= '0;
         below_ff     <= '0;
         act_win_ff   <= '0;
         deact_win_ff <= '0;
         led_ff       <= 1'b0;
      end else if (fire && check) begin
         rc_mode_ff   <= rc_mode_in;
         above_ff     <= above_in;
         below_ff     <= below_in;
         act_win_ff   <= act_win_in;
         deact_win_ff <= deact_win_in;
         led_ff       <= led_in;
      end
   end

   // Select the outputs for this iteration
   assign forwarded     = check && rc_mode_in;
   assign in_brake_band = (item.throttle_width >= cfg.throttle_on_threshold) &&
                          (item.throttle_width <= cfg.throttle_brake_threshold);

   always_comb begin
      result                 = '0;
      result.led_on          = check ? led_in : led_ff;
      result.rc_mode_active  = check ? rc_mode_in : rc_mode_ff;
      if (forwarded) begin
         result.rc_forward      = 1'b1;
         result.rc_throttle_out = item.throttle_width;
         result.rc_steering_out = item.steering_width;
      end else if (item.mode) begin
         result.esc_write   = 1'b1;
         result.esc_value   = cfg.speed_stop_value;
         result.servo_write = 1'b1;
         result.servo_value = cfg.centered_angle_value;
      end else if (in_brake_band) begin
         result.esc_write = 1'b1;
         result.esc_value = cfg.speed_stop_value;
      end else begin
         result.esc_write   = 1'b1;
         result.esc_value   = item.drive_speed;
         result.servo_write = 1'b1;
         result.servo_value = item.drive_angle;
      end
   end

   // The activation window counts down as it loads; the deactivation window
   // may sit at its load value while the activation window is still counting
   assert property (@(posedge clock) disable iff (reset)
      (act_win_ff < WINDOW_LOAD) && (deact_win_ff <= WINDOW_LOAD))
      else $error("centering window above its load value");

   // Mode flag moves only on a transfer with throttle above the on threshold
   assert property (@(posedge clock) disable iff (reset)
      !(fire && check) |=> $stable(rc_mode_ff))
      else $error("mode flag changed without a mode check");

   // LED follows the low bit of the larger window after each mode check
   assert property (@(posedge clock) disable iff (reset)
      (fire && check) |=>
         (led_ff == ((act_win_ff > deact_win_ff) ? act_win_ff[0] : deact_win_ff[0])))
      else $error("LED level out of step with the windows");

endmodule

`default_nettype wire

// ----- dv/rcoms_result_checker.sv -----
`timescale 1ns / 100ps

module rcoms_result_checker
   import rcoms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   rcoms_req_if                  req_ch,
   rcoms_rsp_if                  rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    mismatches,
   output int                    pending,
   output int                    mode_changes
);

   // Shadow registers and mode-switch state
   cfg_type               shadow_cfg;
   logic                  rc_mode;
   logic [COUNT_W-1:0]    above_cnt;
   logic [COUNT_W-1:0]    below_cnt;
   logic [WINDOW_W-1:0]   act_win;
   logic [WINDOW_W-1:0]   deact_win;
   logic                  led;

   rsp_item_type          expected_results[$];
   int                    results_seen;

   // Steering check: counters, centring windows and LED; returns the mode flag
   function automatic logic update_mode(input logic [PULSE_W-1:0] steer);
      int   steer_i;
      int   centre_i;
      logic centred;
      logic was_rc;
      steer_i  = steer;
      centre_i = shadow_cfg.centered_pulse_width;
      centred  = (steer_i > centre_i - CENTER_TOLERANCE) &&
                 (steer_i < centre_i + CENTER_TOLERANCE);
      was_rc   = rc_mode;

      // centred steering inside an open window flips the mode
      if (act_win != 0 && centred) begin
         rc_mode = 1'b1;
      end else if (deact_win != 0 && centred) begin
         rc_mode = 1'b0;
      end
      if (rc_mode != was_rc) begin
         mode_changes++;
      end

      // held deflection counts up, then opens a window
      if (!rc_mode && steer > shadow_cfg.steering_activation_threshold) begin
         if (above_cnt < shadow_cfg.iterations_to_change) begin
            above_cnt = above_cnt + 1'b1;
         end else begin
            act_win = WINDOW_W'(CENTER_WINDOW_ITEMS);
         end
      end else if (rc_mode && steer < shadow_cfg.steering_deactivation_threshold) begin
         if (below_cnt < shadow_cfg.iterations_to_change) begin
            below_cnt = below_cnt + 1'b1;
         end else begin
            deact_win = WINDOW_W'(CENTER_WINDOW_ITEMS);
         end
      end

      // count one window down; LED follows the low bit of the larger one
      if (act_win != 0) begin
         act_win = act_win - 1'b1;
      end else if (deact_win != 0) begin
         deact_win = deact_win - 1'b1;
      end
      led = (act_win > deact_win) ? act_win[0] : deact_win[0];

      // drop below_cnt unless steering is below deactivation, else above_cnt unless above activation
      if (steer >= shadow_cfg.steering_deactivation_threshold) begin
         below_cnt = '0;
      end else if (steer <= shadow_cfg.steering_activation_threshold) begin
         above_cnt = '0;
      end
      return rc_mode;
   endfunction

   // One control iteration: mode check when throttle is above the on threshold, then select the outputs
   function automatic rsp_item_type predict_iteration(input req_item_type it);
      rsp_item_type res;
      logic         forward;
      res     = '0;
      forward = 1'b0;
      if (it.throttle_width > shadow_cfg.throttle_on_threshold) begin
         forward = update_mode(it.steering_width);
      end

      if (forward) begin
         res.rc_forward      = 1'b1;
         res.rc_throttle_out = it.throttle_width;
         res.rc_steering_out = it.steering_width;
      end else if (it.mode) begin
         res.esc_write   = 1'b1;
         res.esc_value   = shadow_cfg.speed_stop_value;
         res.servo_write = 1'b1;
         res.servo_value = shadow_cfg.centered_angle_value;
      end else if (it.throttle_width >= shadow_cfg.throttle_on_threshold &&
                   it.throttle_width <= shadow_cfg.throttle_brake_threshold) begin
         res.esc_write = 1'b1;
         res.esc_value = shadow_cfg.speed_stop_value;
      end else begin
         res.esc_write   = 1'b1;
         res.esc_value   = it.drive_speed;
         res.servo_write = 1'b1;
         res.servo_value = it.drive_angle;
      end
      res.led_on         = led;
      res.rc_mode_active = rc_mode;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      req_item_type item;
      rsp_item_type got;
      rsp_item_type want;
      string        diff;
      if (reset) begin
         shadow_cfg.throttle_on_threshold           = RST_THROTTLE_ON;
         shadow_cfg.throttle_brake_threshold        = RST_THROTTLE_BRAKE;
         shadow_cfg.steering_activation_threshold   = RST_STEER_ACT;
         shadow_cfg.steering_deactivation_threshold = RST_STEER_DEACT;
         shadow_cfg.centered_pulse_width            = RST_CENTERED_PULSE;
         shadow_cfg.iterations_to_change            = RST_ITERATIONS;
         shadow_cfg.speed_stop_value                = RST_SPEED_STOP;
         shadow_cfg.centered_angle_value            = RST_CENTERED_ANGLE;
         rc_mode      = 1'b0;
         above_cnt    = '0;
         below_cnt    = '0;
         act_win      = '0;
         deact_win    = '0;
         led          = 1'b0;
         mismatches   = 0;
         mode_changes = 0;
         results_seen = 0;
         expected_results.delete();
      end else begin
         // compare a result transfer with the oldest expectation
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.esc_write       = rsp_ch.esc_write;
            got.esc_value       = rsp_ch.esc_value;
            got.servo_write     = rsp_ch.servo_write;
            got.servo_value     = rsp_ch.servo_value;
            got.rc_forward      = rsp_ch.rc_forward;
            got.rc_throttle_out = rsp_ch.rc_throttle_out;
            got.rc_steering_out = rsp_ch.rc_steering_out;
            got.led_on          = rsp_ch.led_on;
            got.rc_mode_active  = rsp_ch.rc_mode_active;
            if (expected_results.size() == 0) begin
               if (mismatches < 10) begin
                  $display("result %0d arrived with nothing expected: %h", results_seen, got);
               end
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               diff = "";
               if (got.esc_write !== want.esc_write) diff = {diff, " esc_write"};
               if (got.esc_value !== want.esc_value) diff = {diff, " esc_value"};
               if (got.servo_write !== want.servo_write) diff = {diff, " servo_write"};
               if (got.servo_value !== want.servo_value) diff = {diff, " servo_value"};
               if (got.rc_forward !== want.rc_forward) diff = {diff, " rc_forward"};
               if (got.rc_throttle_out !== want.rc_throttle_out) diff = {diff, " rc_throttle_out"};
               if (got.rc_steering_out !== want.rc_steering_out) diff = {diff, " rc_steering_out"};
               if (got.led_on !== want.led_on) diff = {diff, " led_on"};
               if (got.rc_mode_active !== want.rc_mode_active) diff = {diff, " rc_mode_active"};
               if (diff != "") begin
                  if (mismatches < 10) begin
                     $display("result %0d wrong in%s: expected %h, actual %h",
                              results_seen, diff, want, got);
                  end
                  mismatches++;
               end
            end
            results_seen++;
         end

         // predict the result of a request transfer
         if (req_ch.valid && req_ch.ready) begin
            item.mode           = req_ch.mode;
            item.throttle_width = req_ch.throttle_width;
            item.steering_width = req_ch.steering_width;
            item.drive_speed    = req_ch.drive_speed;
            item.drive_angle    = req_ch.drive_angle;
            expected_results.push_back(predict_iteration(item));
         end

         // track register writes
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_THROTTLE_ON:    shadow_cfg.throttle_on_threshold = csr_write_data;
               CSR_THROTTLE_BRAKE: shadow_cfg.throttle_brake_threshold = csr_write_data;
               CSR_STEER_ACT:      shadow_cfg.steering_activation_threshold = csr_write_data;
               CSR_STEER_DEACT:    shadow_cfg.steering_deactivation_threshold = csr_write_data;
               CSR_CENTERED_PULSE: shadow_cfg.centered_pulse_width = csr_write_data;
               CSR_ITERATIONS:     shadow_cfg.iterations_to_change = csr_write_data[COUNT_W-1:0];
               CSR_SPEED_STOP:     shadow_cfg.speed_stop_value = csr_write_data[CODE_W-1:0];
               CSR_CENTERED_ANGLE: shadow_cfg.centered_angle_value = csr_write_data[CODE_W-1:0];
               default: ;
            endcase
         end
      end
      pending = expected_results.size();
   end

endmodule

// ----- dv/tb_rc_override_mode_switch.sv -----
`timescale 1ns / 100ps

module tb_rc_override_mode_switch;
   import rcoms_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   rcoms_req_if req_if ();
   rcoms_rsp_if rsp_if ();

   int      mismatches;
   int      pending;
   int      mode_changes;
   cfg_type live_cfg;
   int      items_sent       = 0;
   int      settings_applied = 0;
   int      stall_left       = 0;
   int      idle_cycles      = 0;
   logic    steady           = 1'b0;
   logic    toward_rc        = 1'b0;

   rc_override_mode_switch u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   rcoms_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .pending          (pending),
      .mode_changes     (mode_changes)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Abort when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results pending",
                  IDLE_LIMIT, pending);
         $display("tb_rc_override_mode_switch NOT OK");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = int'($urandom_range(0, 99));
      if (steady || roll < 60) return 0;
      if (roll < 92) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   // Receiver: stall the result channel at random
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready = 1'b0;
      end else if (steady) begin
         rsp_if.ready = 1'b1;
      end else if (stall_left > 0) begin
         rsp_if.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_if.ready = 1'b1;
         stall_left   = pick_gap();
      end
   end

   // Random field values at their own widths
   function automatic logic rand_bit();
      return 1'($urandom);
   endfunction

   function automatic logic [PULSE_W-1:0] rand_pulse();
      return PULSE_W'($urandom);
   endfunction

   function automatic logic [CODE_W-1:0] rand_code();
      return CODE_W'($urandom);
   endfunction

   function automatic req_item_type make_item(input logic m,
                                              input logic [PULSE_W-1:0] thr,
                                              input logic [PULSE_W-1:0] steer,
                                              input logic [CODE_W-1:0] spd,
                                              input logic [CODE_W-1:0] ang);
      req_item_type it;
      it.mode           = m;
      it.throttle_width = thr;
      it.steering_width = steer;
      it.drive_speed    = spd;
      it.drive_angle    = ang;
      return it;
   endfunction

   function automatic cfg_type make_cfg(input logic [PULSE_W-1:0] on_thr,
                                        input logic [PULSE_W-1:0] brake_thr,
                                        input logic [PULSE_W-1:0] act_thr,
                                        input logic [PULSE_W-1:0] deact_thr,
                                        input logic [PULSE_W-1:0] centre,
                                        input logic [COUNT_W-1:0] iters,
                                        input logic [CODE_W-1:0] stop_code,
                                        input logic [CODE_W-1:0] centre_angle);
      cfg_type c;
      c.throttle_on_threshold           = on_thr;
      c.throttle_brake_threshold        = brake_thr;
      c.steering_activation_threshold   = act_thr;
      c.steering_deactivation_threshold = deact_thr;
      c.centered_pulse_width            = centre;
      c.iterations_to_change            = iters;
      c.speed_stop_value                = stop_code;
      c.centered_angle_value            = centre_angle;
      return c;
   endfunction

   function automatic logic [PULSE_W-1:0] pulse_above(input logic [PULSE_W-1:0] x);
      if (x == '1) return x;
      return PULSE_W'($urandom_range(int'(x) + 1, 65535));
   endfunction

   function automatic logic [PULSE_W-1:0] pulse_below(input logic [PULSE_W-1:0] x);
      if (x == '0) return x;
      return PULSE_W'($urandom_range(0, int'(x) - 1));
   endfunction

   // Steering strictly inside the centring tolerance
   function automatic logic [PULSE_W-1:0] pulse_centred();
      int lo;
      int hi;
      lo = int'(live_cfg.centered_pulse_width) - (CENTER_TOLERANCE - 1);
      hi = int'(live_cfg.centered_pulse_width) + (CENTER_TOLERANCE - 1);
      if (lo < 0) lo = 0;
      if (hi > 65535) hi = 65535;
      return PULSE_W'($urandom_range(lo, hi));
   endfunction

   // Present one request after a random gap; return once it is taken
   task automatic send_request(input req_item_type it);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid          = 1'b1;
      req_if.mode           = it.mode;
      req_if.throttle_width = it.throttle_width;
      req_if.steering_width = it.steering_width;
      req_if.drive_speed    = it.drive_speed;
      req_if.drive_angle    = it.drive_angle;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   // Hold the sender until every expected result has come back
   task automatic drain_results();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic apply_settings(input cfg_type c);
      csr_index_type reg_idx;
      drain_results();
      reg_idx = reg_idx.first();
      repeat (8) begin
         @(negedge clock);
         csr_write_enable = 1'b1;
         csr_index        = reg_idx;
         case (reg_idx)
            CSR_THROTTLE_ON:    csr_write_data = c.throttle_on_threshold;
            CSR_THROTTLE_BRAKE: csr_write_data = c.throttle_brake_threshold;
            CSR_STEER_ACT:      csr_write_data = c.steering_activation_threshold;
            CSR_STEER_DEACT:    csr_write_data = c.steering_deactivation_threshold;
            CSR_CENTERED_PULSE: csr_write_data = c.centered_pulse_width;
            CSR_ITERATIONS:     csr_write_data = CSR_DATA_W'(c.iterations_to_change);
            CSR_SPEED_STOP:     csr_write_data = CSR_DATA_W'(c.speed_stop_value);
            CSR_CENTERED_ANGLE: csr_write_data = CSR_DATA_W'(c.centered_angle_value);
            default:            csr_write_data = '0;
         endcase
         reg_idx = reg_idx.next();
      end
      @(negedge clock);
      csr_write_enable = 1'b0;
      live_cfg = c;
      settings_applied++;
   endtask

   // Throttle active, so the mode check runs
   task automatic send_active(input logic [PULSE_W-1:0] steer);
      send_request(make_item(($urandom_range(0, 3) == 0),
                             pulse_above(live_cfg.throttle_on_threshold),
                             steer, rand_code(), rand_code()));
   endtask

   task automatic send_noise();
      logic [PULSE_W-1:0] on_thr;
      logic [PULSE_W-1:0] brake_thr;
      on_thr    = live_cfg.throttle_on_threshold;
      brake_thr = live_cfg.throttle_brake_threshold;
      case ($urandom_range(0, 3))
         0: send_request(make_item(rand_bit(), rand_pulse(), rand_pulse(),
                                   rand_code(), rand_code()));
         1: send_request(make_item(rand_bit(), PULSE_W'($urandom_range(0, on_thr)),
                                   rand_pulse(), rand_code(), rand_code()));
         2: begin
            if (on_thr <= brake_thr) begin
               send_request(make_item(rand_bit(),
                                      PULSE_W'($urandom_range(on_thr, brake_thr)),
                                      rand_pulse(), rand_code(), rand_code()));
            end else begin
               send_active(rand_pulse());
            end
         end
         default: send_request(make_item(1'b1, rand_pulse(), rand_pulse(),
                                         rand_code(), rand_code()));
      endcase
   endtask

   // Hold a deflection, then centre the steering: sometimes too short or too late
   task automatic attempt_switch();
      int hold;
      int filler;
      toward_rc = ~toward_rc;
      hold = int'(live_cfg.iterations_to_change) + int'($urandom_range(0, 3));
      repeat (hold) begin
         if (toward_rc) begin
            send_active(pulse_above(live_cfg.steering_activation_threshold));
         end else begin
            send_active(pulse_below(live_cfg.steering_deactivation_threshold));
         end
      end
      filler = ($urandom_range(0, 9) == 0) ? int'($urandom_range(4, 12)) :
                                             int'($urandom_range(0, 2));
      repeat (filler) send_active(rand_pulse());
      send_active(pulse_centred());
      repeat ($urandom_range(0, 6)) send_active(rand_pulse());
   endtask

   task automatic run_traffic(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) begin
         steady = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 99) < 55) begin
            attempt_switch();
         end else begin
            repeat ($urandom_range(1, 6)) send_noise();
         end
         if ($urandom_range(0, 49) == 0) begin
            drain_results();
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      int thr_on;
      req_if.valid          = 1'b0;
      req_if.mode           = 1'b0;
      req_if.throttle_width = '0;
      req_if.steering_width = '0;
      req_if.drive_speed    = '0;
      req_if.drive_angle    = '0;
      rsp_if.ready          = 1'b0;
      csr_write_enable      = 1'b0;
      csr_index             = CSR_THROTTLE_ON;
      csr_write_data        = '0;
      live_cfg = make_cfg(RST_THROTTLE_ON, RST_THROTTLE_BRAKE, RST_STEER_ACT,
                          RST_STEER_DEACT, RST_CENTERED_PULSE, RST_ITERATIONS,
                          RST_SPEED_STOP, RST_CENTERED_ANGLE);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes, throttle at and around the thresholds,
      // stop request, brake band and both edges of the centring tolerance
      send_request(make_item(1'b0, 16'd0,     16'd0,     8'hFF, 8'h00));
      send_request(make_item(1'b0, 16'd1200,  16'd1500,  8'h12, 8'h34));
      send_request(make_item(1'b1, 16'd1200,  16'd1500,  8'h56, 8'h78));
      send_request(make_item(1'b0, 16'd1250,  16'd1500,  8'h9A, 8'hBC));
      send_request(make_item(1'b0, 16'd1301,  16'hFFFF,  8'h00, 8'hFF));
      send_request(make_item(1'b0, 16'hFFFF,  16'd1450,  8'h11, 8'h22));
      send_request(make_item(1'b0, 16'hFFFF,  16'd1451,  8'h33, 8'h44));
      send_request(make_item(1'b0, 16'd2000,  16'd1549,  8'h55, 8'h66));
      send_request(make_item(1'b0, 16'd2000,  16'd1550,  8'h77, 8'h88));
      send_request(make_item(1'b1, 16'hFFFF,  16'd1800,  8'h99, 8'hAA));
      send_request(make_item(1'b0, 16'd1300,  16'd1199,  8'hBB, 8'hCC));
      send_request(make_item(1'b1, 16'd1201,  16'd0,     8'hAA, 8'h55));
      send_request(make_item(1'b0, 16'hFFFF,  16'hFFFF,  8'hFF, 8'hFF));
      send_request(make_item(1'b1, 16'd1199,  16'd1500,  8'h01, 8'h80));

      // Default thresholds and centre with a short hold, so windows open often
      apply_settings(make_cfg(16'd1200, 16'd1300, 16'd1800, 16'd1200, 16'd1500,
                              8'd3, 8'd7, 8'd90));
      run_traffic(240);
      // All registers at zero
      apply_settings(make_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0));
      run_traffic(80);
      // All registers at their maximum
      apply_settings(make_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              8'hFF, 8'hFF, 8'hFF));
      run_traffic(30);
      // Centre near zero, brake below the on threshold
      apply_settings(make_cfg(16'd1000, 16'd900, 16'd100, 16'd10, 16'd20,
                              8'd1, 8'd200, 8'd45));
      run_traffic(150);
      // Centre near the top, deactivation above activation
      apply_settings(make_cfg(16'd300, 16'd40000, 16'd60000, 16'd65000, 16'd65530,
                              8'd2, 8'd33, 8'd130));
      run_traffic(150);
      // Longest hold
      apply_settings(make_cfg(16'd1200, 16'd1300, 16'd1800, 16'd1200, 16'd1500,
                              8'd255, 8'd0, 8'd90));
      run_traffic(300);
      // Random settings around the usual values
      repeat (3) begin
         thr_on = int'($urandom_range(800, 1600));
         apply_settings(make_cfg(PULSE_W'(thr_on),
                                 PULSE_W'(thr_on + int'($urandom_range(0, 400))),
                                 PULSE_W'($urandom_range(1500, 2000)),
                                 PULSE_W'($urandom_range(1000, 1500)),
                                 PULSE_W'($urandom_range(1300, 1700)),
                                 COUNT_W'($urandom_range(0, 6)),
                                 rand_code(), rand_code()));
         run_traffic(100);
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Summary: %0d requests over %0d register settings plus defaults,",
               items_sent, settings_applied);
      $display("         %0d RC mode changes, %0d mismatches", mode_changes, mismatches);
      if (mismatches == 0 && pending == 0) begin
         $display("tb_rc_override_mode_switch OK");
      end else begin
         $display("tb_rc_override_mode_switch NOT OK");
      end
      $finish;
   end

endmodule
